// File: hw/rtl/ssi_pkg.sv
`default_nettype none

package ssi_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int ELEM_W       = 10;
	localparam int KIND_W       = 2;
	localparam int UNIV_W       = 11;
	localparam int CMP_W        = ELEM_W + UNIV_W + CNT_W;
	localparam int S_TDATA_W    = ((ELEM_W + 7) / 8) * 8;
	localparam int M_TDATA_W    = ((CNT_W + 7) / 8) * 8;
	localparam int UNIV_RESET   = 1024;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	typedef struct packed {
		logic             capture;
		logic             dense_rd;
		logic             commit;
		logic             init_wr;
		logic [IDX_W-1:0] init_addr;
	} ssi_cmd_t;

	typedef struct packed {
		logic out_free;
	} ssi_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/sparse_index_set.sv
// Channel  | Signals                        | Content
// s_       | tvalid tready tdata tuser      | operation item: element, kind
// m_       | tvalid tready tdata tuser      | result item: count, flags
// cfg_     | wr_en wr_data                  | universe size register
//
// Every operation has three steps: a position map read, a member list read and the
// evaluation with write-back; its result is registered when the evaluation commits.
// A new item can be accepted at the clock edge after the previous result is registered.
// After reset a sweep zeroes every entry of the position map; no item is
// accepted during it. A clear empties the set at once by zeroing the member count.
// A stalled result holds the block in evaluation until the output register is free.
`default_nettype none

module sparse_index_set
	import ssi_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [UNIV_W-1:0]    cfg_wr_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // element
	input  wire logic [KIND_W-1:0]    s_tuser,  // kind
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,  // count
	output logic [1:0]                m_tuser   // out_of_range, was_member
);

	ssi_cmd_t cmd;
	ssi_sts_t sts;

	ssi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssi_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_kind     (s_tuser),
		.in_element  (s_tdata[ELEM_W-1:0]),
		.cmd         (cmd),
		.sts         (sts),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule

`default_nettype wire

// File: hw/rtl/ssi_ctrl.sv
`default_nettype none

module ssi_ctrl
	import ssi_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire ssi_sts_t sts,
	output ssi_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_DENSE,
		ST_EVAL
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] init_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (init_cnt_q == IDX_W'(MAX_ELEMENTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DENSE;
					end
				end
				ST_DENSE: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.init_addr = init_cnt_q;
		cmd.init_wr   = (state_q == ST_INIT);
		cmd.capture   = (state_q == ST_IDLE) && s_tvalid;
		cmd.dense_rd  = (state_q == ST_DENSE);
		cmd.commit    = (state_q == ST_EVAL) && sts.out_free;
	end

endmodule

`default_nettype wire

// File: hw/rtl/ssi_dpath.sv
`default_nettype none

module ssi_dpath
	import ssi_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [UNIV_W-1:0]     cfg_wr_data,
	input  wire logic [KIND_W-1:0]     in_kind,
	input  wire logic [ELEM_W-1:0]     in_element,
	input  wire ssi_cmd_t              cmd,
	output ssi_sts_t                   sts,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_TDATA_W-1:0]       m_tdata,
	output logic [1:0]                 m_tuser
);

	logic [IDX_W-1:0]  map_mem   [MAX_ELEMENTS];
	logic [ELEM_W-1:0] dense_mem [MAX_ELEMENTS];

	logic [UNIV_W-1:0] universe_q;
	logic [CNT_W-1:0]  count_q;
	logic [KIND_W-1:0] kind_q;
	logic [ELEM_W-1:0] elem_q;
	logic [IDX_W-1:0]  pos_q;
	logic [ELEM_W-1:0] dense_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_was_q;
	logic              out_oor_q;

	logic              in_range;
	logic              member;
	logic              is_access;
	logic              do_insert;
	logic              was;
	logic              oor;
	logic [CNT_W-1:0]  count_next;
	logic              map_we;
	logic [IDX_W-1:0]  map_waddr;
	logic [IDX_W-1:0]  map_wdata;

	assign in_range = (CMP_W'(elem_q) < CMP_W'(universe_q))
		&& (CMP_W'(elem_q) < CMP_W'(MAX_ELEMENTS));
	assign member = (CNT_W'(pos_q) < count_q) && (dense_q == elem_q);
	assign is_access = (kind_q == KIND_INSERT) || (kind_q == KIND_QUERY);

	always_comb begin
		was        = 1'b0;
		oor        = 1'b0;
		do_insert  = 1'b0;
		count_next = count_q;
		case (kind_q) inside
			KIND_INSERT, KIND_QUERY: begin
				if (!in_range) begin
					oor = 1'b1;
				end else begin
					was = member;
					if (kind_q == KIND_INSERT && !member
						&& count_q < CNT_W'(MAX_ELEMENTS)) begin
						do_insert  = 1'b1;
						count_next = count_q + 1'b1;
					end
				end
			end
			KIND_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	assign map_we    = cmd.init_wr || (cmd.commit && do_insert);
	assign map_waddr = cmd.init_wr ? cmd.init_addr : IDX_W'(elem_q);
	assign map_wdata = cmd.init_wr ? '0 : count_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		if (cmd.capture) begin
			pos_q <= map_mem[IDX_W'(in_element)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && do_insert) begin
			dense_mem[count_q[IDX_W-1:0]] <= elem_q;
		end
		if (cmd.dense_rd) begin
			dense_q <= dense_mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			elem_q <= in_element;
		end
		if (cmd.commit) begin
			out_count_q <= count_next;
			out_was_q   <= was && is_access;
			out_oor_q   <= oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			universe_q  <= UNIV_W'(UNIV_RESET);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				universe_q <= cfg_wr_data;
			end
			if (cmd.commit) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = M_TDATA_W'(out_count_q);
	assign m_tuser      = {out_oor_q, out_was_q};

endmodule

`default_nettype wire

// File: hw/rtl/ssi_checker.sv
`default_nettype none

module ssi_checker
	import ssi_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [1:0]           m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while another is in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= M_TDATA_W'(MAX_ELEMENTS))
		else $error("member count above capacity");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("refused index reported as member");

endmodule

bind sparse_index_set ssi_checker u_ssi_checker (.*);

`default_nettype wire
